// File: rtl/core/utf8dc_pkg.sv
// ----------------------------------------------------------------------------
// utf8dc_pkg
// Types and constants shared by the UTF-8 decode and classify unit: the
// window and result transfer types, byte masks and the classification lists.
// ----------------------------------------------------------------------------
package utf8dc_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned AVAIL_W = 3;

    // one input window
    typedef struct packed {
        logic [7:0]         lead_byte;
        logic [7:0]         second_byte;
        logic [7:0]         third_byte;
        logic [7:0]         fourth_byte;
        logic [AVAIL_W-1:0] avail_bytes;
    } win_item_t;

    // one decode result
    typedef struct packed {
        logic             valid_res;
        logic [CP_W-1:0]  char_value;
        logic [LEN_W-1:0] seq_length;
        logic             space_flag;
        logic             hyphen_flag;
        logic             cjk_flag;
    } res_item_t;

    // lead and continuation byte patterns
    localparam logic [7:0] ONE_MASK   = 8'h80;
    localparam logic [7:0] ONE_PAT    = 8'h00;
    localparam logic [7:0] TWO_MASK   = 8'he0;
    localparam logic [7:0] TWO_PAT    = 8'hc0;
    localparam logic [7:0] THREE_MASK = 8'hf0;
    localparam logic [7:0] THREE_PAT  = 8'he0;
    localparam logic [7:0] FOUR_MASK  = 8'hf8;
    localparam logic [7:0] FOUR_PAT   = 8'hf0;
    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_PAT   = 8'h80;

    // sequence lengths
    localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;
    localparam logic [AVAIL_W-1:0] AVAIL_MAX = 3'd4;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_PAT;
    endfunction

    function automatic logic in_space_list(input logic [CP_W-1:0] cp);
        return cp == 21'h00009 || cp == 21'h00020 || cp == 21'h01680 ||
               (cp >= 21'h02002 && cp <= 21'h02006) ||
               (cp >= 21'h02008 && cp <= 21'h0200b) ||
               cp == 21'h0205f || cp == 21'h03000;
    endfunction

    function automatic logic in_hyphen_list(input logic [CP_W-1:0] cp);
        return cp == 21'h0002d || cp == 21'h0058a || cp == 21'h02010 ||
               cp == 21'h02012 || cp == 21'h02013;
    endfunction

    function automatic logic in_cjk_range(input logic [CP_W-1:0] cp);
        return (cp >= 21'h02e80 && cp <= 21'h0312f) ||
               (cp >= 21'h03190 && cp <= 21'h0a4cf) ||
               (cp >= 21'h0f900 && cp <= 21'h0faff) ||
               (cp >= 21'h0fe30 && cp <= 21'h0fe4f) ||
               (cp >= 21'h20000 && cp <= 21'h323af);
    endfunction

endpackage

// File: rtl/core/utf8_decode_and_classify_unit.sv
// ----------------------------------------------------------------------------
// utf8_decode_and_classify_unit
// Decodes the first UTF-8 sequence of a four-byte window and flags the code
// point as whitespace, hyphen or CJK.
// ----------------------------------------------------------------------------
// Usage:
//   win channel: win_valid / win_ready / win carry one window per transfer
//   (four bytes plus the count of bytes present, saturating at four).
//   res channel: res_valid / res_ready / res carry one result per window,
//   in order: valid bit, code point, length and the three class flags.
//   Path: a window accepted on win passes through the input register and then
//   the result register, which drives res.
//   Throughput: one window per cycle while res_ready stays high; the decode and
//   classification is a single pass of logic between the input and result registers.
//   Stall: when res_ready is low the result register holds; the input
//   register still takes one more window, after which win_ready drops until
//   the result is taken. No transfer is lost or repeated.
//   Reset: rst_n low empties both registers; win_ready is high right after.
// ----------------------------------------------------------------------------
module utf8_decode_and_classify_unit
    import utf8dc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      win_valid,
    output logic      win_ready,
    input  win_item_t win,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res
);

    logic      stg_valid_reg;
    logic      stg_valid_next;
    win_item_t stg_data_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    res_item_t out_data_reg;
    res_item_t dec_res;
    logic      stg_move;
    logic      win_take;

    logic [AVAIL_W-1:0] avail_sat;
    logic [LEN_W-1:0]   need;
    logic [CP_W-1:0]    cp_raw;
    logic               form_ok;
    logic               ok;
    logic [CP_W-1:0]    cp;

    // handshake control
    assign stg_move  = stg_valid_reg && (!out_valid_reg || res_ready);
    assign win_ready = !stg_valid_reg || stg_move;
    assign win_take  = win_valid && win_ready;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (win_take)
        begin
            stg_valid_next = 1'b1;
        end
        else if (stg_move)
        begin
            stg_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (stg_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // lead byte form and code point assembly
    always_comb
    begin
        need    = LEN_NONE;
        cp_raw  = '0;
        form_ok = 1'b0;
        if ((stg_data_reg.lead_byte & ONE_MASK) == ONE_PAT)
        begin
            need    = LEN_ONE;
            cp_raw  = {13'd0, stg_data_reg.lead_byte};
            form_ok = 1'b1;
        end
        else if ((stg_data_reg.lead_byte & TWO_MASK) == TWO_PAT)
        begin
            need    = LEN_TWO;
            form_ok = is_cont(stg_data_reg.second_byte);
            cp_raw  = {10'd0, stg_data_reg.lead_byte[4:0],
                       stg_data_reg.second_byte[5:0]};
        end
        else if ((stg_data_reg.lead_byte & THREE_MASK) == THREE_PAT)
        begin
            need    = LEN_THREE;
            form_ok = is_cont(stg_data_reg.second_byte) &&
                      is_cont(stg_data_reg.third_byte);
            cp_raw  = {5'd0, stg_data_reg.lead_byte[3:0],
                       stg_data_reg.second_byte[5:0],
                       stg_data_reg.third_byte[5:0]};
        end
        else if ((stg_data_reg.lead_byte & FOUR_MASK) == FOUR_PAT)
        begin
            need    = LEN_FOUR;
            form_ok = is_cont(stg_data_reg.second_byte) &&
                      is_cont(stg_data_reg.third_byte) &&
                      is_cont(stg_data_reg.fourth_byte);
            cp_raw  = {stg_data_reg.lead_byte[2:0],
                       stg_data_reg.second_byte[5:0],
                       stg_data_reg.third_byte[5:0],
                       stg_data_reg.fourth_byte[5:0]};
        end
    end

    // length check and classification
    always_comb
    begin
        avail_sat = (stg_data_reg.avail_bytes > AVAIL_MAX) ? AVAIL_MAX
                                                           : stg_data_reg.avail_bytes;
        ok = form_ok && (need != LEN_NONE) && (avail_sat >= need);
        cp = ok ? cp_raw : '0;
        dec_res.valid_res   = ok;
        dec_res.char_value  = cp;
        dec_res.seq_length  = ok ? need : LEN_NONE;
        dec_res.space_flag  = ok && in_space_list(cp);
        dec_res.hyphen_flag = ok && in_hyphen_list(cp);
        dec_res.cjk_flag    = ok && in_cjk_range(cp);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (win_take)
        begin
            stg_data_reg <= win;
        end
        if (stg_move)
        begin
            out_data_reg <= dec_res;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

endmodule

// File: tb/tb_utf8_decode_and_classify_unit.sv
// ----------------------------------------------------------------------------
// tb_utf8_decode_and_classify_unit
// Self-checking testbench for the UTF-8 decode and classify unit. A short
// table of windows (empty, too short, broken continuations, bad lead bytes,
// extremes of the code point range, class list edges) runs first. Random
// windows follow, mostly well-formed sequences. Every result is checked
// field by field against its table row's own result or a local decoder,
// with random gaps on both channels and one long receiver hold-off that backs the unit up into its input.
// ----------------------------------------------------------------------------
module tb_utf8_decode_and_classify_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8dc_pkg::*;

    localparam int RANDOM_ITEMS    = 1525;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int REPORT_MAX      = 10;
    localparam int HOLD_OFF_AT     = 200;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int BURST_FROM      = 180;
    localparam int BURST_TO        = 320;
    localparam int TABLE_ROWS      = 26;
    localparam int EDGE_COUNT      = 24;

    localparam res_item_t NO_DECODE = '0;

    // code points at the edges of the whitespace, hyphen and cjk lists
    localparam logic [CP_W-1:0] CLASS_EDGES [EDGE_COUNT] = '{
        21'h00009, 21'h00020, 21'h0002d, 21'h0058a, 21'h01680, 21'h02002,
        21'h02006, 21'h02008, 21'h0200b, 21'h02010, 21'h02012, 21'h02013,
        21'h0205f, 21'h03000, 21'h02e80, 21'h0312f, 21'h03190, 21'h0a4cf,
        21'h0f900, 21'h0faff, 21'h0fe30, 21'h0fe4f, 21'h20000, 21'h323af
    };

    typedef struct {
        win_item_t w;
        bit        typed;
        res_item_t want;
    } dir_row_t;

    // directed windows; typed rows carry their result, the rest use the decoder
    dir_row_t window_table [TABLE_ROWS] = '{
        '{{8'h41, 8'h00, 8'h00, 8'h00, 3'd0}, 1'b1, NO_DECODE},
        '{{8'h00, 8'hff, 8'hff, 8'hff, 3'd1}, 1'b1, {1'b1, 21'h000000, LEN_ONE, 3'b000}},
        '{{8'h7f, 8'h00, 8'h00, 8'h00, 3'd4}, 1'b1, {1'b1, 21'h00007f, LEN_ONE, 3'b000}},
        '{{8'h09, 8'h20, 8'h00, 8'h00, 3'd1}, 1'b0, NO_DECODE},
        '{{8'h2d, 8'h00, 8'h00, 8'h00, 3'd4}, 1'b0, NO_DECODE},
        '{{8'he2, 8'h80, 8'hc0, 8'h00, 3'd3}, 1'b1, NO_DECODE},
        '{{8'hc2, 8'h80, 8'h00, 8'h00, 3'd2}, 1'b0, NO_DECODE},
        '{{8'hc2, 8'h80, 8'h00, 8'h00, 3'd1}, 1'b1, NO_DECODE},
        '{{8'hc3, 8'h41, 8'h00, 8'h00, 3'd4}, 1'b1, NO_DECODE},
        '{{8'h80, 8'h80, 8'h80, 8'h80, 3'd4}, 1'b1, NO_DECODE},
        '{{8'hf8, 8'h80, 8'h80, 8'h80, 3'd4}, 1'b1, NO_DECODE},
        '{{8'hff, 8'hff, 8'hff, 8'hff, 3'd7}, 1'b1, NO_DECODE},
        '{{8'he1, 8'h9a, 8'h80, 8'h00, 3'd3}, 1'b0, NO_DECODE},
        '{{8'he2, 8'h80, 8'h93, 8'h00, 3'd3}, 1'b0, NO_DECODE},
        '{{8'he3, 8'h80, 8'h80, 8'h00, 3'd4}, 1'b0, NO_DECODE},
        '{{8'he2, 8'hba, 8'h80, 8'h00, 3'd3}, 1'b0, NO_DECODE},
        '{{8'hf0, 8'hb2, 8'h8e, 8'haf, 3'd4}, 1'b0, NO_DECODE},
        '{{8'hf0, 8'hb2, 8'h8e, 8'hb0, 3'd4}, 1'b0, NO_DECODE},
        '{{8'hf7, 8'hbf, 8'hbf, 8'hbf, 3'd4}, 1'b1, {1'b1, 21'h1fffff, LEN_FOUR, 3'b000}},
        '{{8'hf4, 8'h8f, 8'hbf, 8'hbf, 3'd3}, 1'b1, NO_DECODE},
        '{{8'hf0, 8'h90, 8'h80, 8'h41, 3'd4}, 1'b1, NO_DECODE},
        '{{8'he0, 8'h80, 8'h80, 8'h00, 3'd5}, 1'b1, {1'b1, 21'h000000, LEN_THREE, 3'b000}},
        '{{8'hed, 8'ha0, 8'h80, 8'h00, 3'd3}, 1'b0, NO_DECODE},
        '{{8'hc0, 8'h80, 8'h00, 8'h00, 3'd6}, 1'b0, NO_DECODE},
        '{{8'hd6, 8'h8a, 8'h00, 8'h00, 3'd2}, 1'b0, NO_DECODE},
        '{{8'he2, 8'h80, 8'h8b, 8'hff, 3'd4}, 1'b0, NO_DECODE}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      win_valid = 1'b0;
    win_item_t win       = '0;
    logic      res_ready = 1'b0;
    logic      win_ready;
    logic      res_valid;
    res_item_t res;

    res_item_t pending_results [$];
    int        mismatches  = 0;
    int        sent_count  = 0;
    int        got_count   = 0;
    int        idle_cycles = 0;
    bit        tx_calm     = 1'b0;

    always #10 clk = ~clk;

    utf8_decode_and_classify_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .win       (win),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // decode the first sequence of a window and classify its code point
    function automatic res_item_t decode_window(input win_item_t w);
        res_item_t          r;
        logic [AVAIL_W-1:0] avail;
        logic [LEN_W-1:0]   need;
        logic [CP_W-1:0]    cp;
        logic               cont_ok;
        r       = NO_DECODE;
        avail   = (w.avail_bytes > AVAIL_MAX) ? AVAIL_MAX : w.avail_bytes;
        need    = LEN_NONE;
        cp      = '0;
        cont_ok = 1'b1;
        if (w.lead_byte[7] == 1'b0)
        begin
            need = LEN_ONE;
            cp   = {14'b0, w.lead_byte[6:0]};
        end
        else if (w.lead_byte[7:5] == 3'b110)
        begin
            need    = LEN_TWO;
            cont_ok = w.second_byte[7:6] == 2'b10;
            cp      = {10'b0, w.lead_byte[4:0], w.second_byte[5:0]};
        end
        else if (w.lead_byte[7:4] == 4'b1110)
        begin
            need    = LEN_THREE;
            cont_ok = w.second_byte[7:6] == 2'b10 && w.third_byte[7:6] == 2'b10;
            cp      = {5'b0, w.lead_byte[3:0], w.second_byte[5:0], w.third_byte[5:0]};
        end
        else if (w.lead_byte[7:3] == 5'b11110)
        begin
            need    = LEN_FOUR;
            cont_ok = w.second_byte[7:6] == 2'b10 && w.third_byte[7:6] == 2'b10 &&
                      w.fourth_byte[7:6] == 2'b10;
            cp      = {w.lead_byte[2:0], w.second_byte[5:0], w.third_byte[5:0],
                       w.fourth_byte[5:0]};
        end
        if (need != LEN_NONE && cont_ok && avail >= need)
        begin
            r.valid_res   = 1'b1;
            r.char_value  = cp;
            r.seq_length  = need;
            r.space_flag  = cp inside {21'h00009, 21'h00020, 21'h01680,
                                       [21'h02002:21'h02006], [21'h02008:21'h0200b],
                                       21'h0205f, 21'h03000};
            r.hyphen_flag = cp inside {21'h0002d, 21'h0058a, 21'h02010, 21'h02012,
                                       21'h02013};
            r.cjk_flag    = cp inside {[21'h02e80:21'h0312f], [21'h03190:21'h0a4cf],
                                       [21'h0f900:21'h0faff], [21'h0fe30:21'h0fe4f],
                                       [21'h20000:21'h323af]};
        end
        return r;
    endfunction

    // offer one window and record its expected result on transfer
    task automatic send_window(input win_item_t w, input bit typed, input res_item_t want);
        int gap;
        if (sent_count % 64 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        gap = (tx_calm || (sent_count >= BURST_FROM && sent_count < BURST_TO)) ?
              0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            win_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        win_valid <= 1'b1;
        win       <= w;
        do @(posedge clk); while (!win_ready);
        pending_results.push_back(typed ? want : decode_window(w));
        sent_count++;
    endtask

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (win_valid && win_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side: random stalls, one long hold-off, compare with oldest expectation
    initial
    begin
        int        stall;
        bit        rx_calm;
        res_item_t want;
        rx_calm = 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (got_count % 64 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (got_count == HOLD_OFF_AT)
                stall = HOLD_OFF_CYCLES;
            else
                stall = rx_calm ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            got_count++;
            if (pending_results.size() == 0)
            begin
                if (mismatches < REPORT_MAX)
                    $display("result %0d with nothing pending: %p", got_count, res);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res.valid_res !== want.valid_res || res.char_value !== want.char_value ||
                    res.seq_length !== want.seq_length ||
                    res.space_flag !== want.space_flag ||
                    res.hyphen_flag !== want.hyphen_flag || res.cjk_flag !== want.cjk_flag)
                begin
                    if (mismatches < REPORT_MAX)
                        $display("result %0d mismatch: expected %p, got %p",
                                 got_count, want, res);
                    mismatches++;
                end
            end
        end
    end

    // window side: reset, directed table, random windows, drain
    initial
    begin
        int                 pick;
        int                 k;
        logic [LEN_W-1:0]   len;
        logic [CP_W-1:0]    cp;
        logic [7:0]         bytes [4];
        logic [AVAIL_W-1:0] avail;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < TABLE_ROWS; r++)
            send_window(window_table[r].w, window_table[r].typed, window_table[r].want);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            for (k = 0; k < 4; k++)
                bytes[k] = 8'($urandom);
            avail = 3'($urandom);
            if (pick < 70)
            begin
                // well-formed sequence, near a class edge or with random content
                if ($urandom_range(0, 2) == 0)
                begin
                    cp  = CLASS_EDGES[$urandom_range(0, EDGE_COUNT - 1)] +
                          21'($urandom_range(0, 2)) - 21'd1;
                    len = (cp < 21'h80) ? LEN_ONE : (cp < 21'h800) ? LEN_TWO :
                          (cp < 21'h10000) ? LEN_THREE : LEN_FOUR;
                    // overlong form now and then
                    if ($urandom_range(0, 4) == 0)
                        len = 3'($urandom_range(len, LEN_FOUR));
                end
                else
                begin
                    cp  = 21'($urandom);
                    len = 3'($urandom_range(LEN_ONE, LEN_FOUR));
                end
                case (len)
                    LEN_ONE:
                        bytes[0] = {1'b0, cp[6:0]};
                    LEN_TWO:
                    begin
                        bytes[0] = {3'b110, cp[10:6]};
                        bytes[1] = {2'b10, cp[5:0]};
                    end
                    LEN_THREE:
                    begin
                        bytes[0] = {4'b1110, cp[15:12]};
                        bytes[1] = {2'b10, cp[11:6]};
                        bytes[2] = {2'b10, cp[5:0]};
                    end
                    default:
                    begin
                        bytes[0] = {5'b11110, cp[20:18]};
                        bytes[1] = {2'b10, cp[17:12]};
                        bytes[2] = {2'b10, cp[11:6]};
                        bytes[3] = {2'b10, cp[5:0]};
                    end
                endcase
                // broken continuation byte
                if (len > LEN_ONE && $urandom_range(0, 6) == 0)
                begin
                    k = $urandom_range(1, len - 1);
                    bytes[k][7:6] = 2'($urandom_range(0, 2));
                    if (bytes[k][7:6] == 2'b10)
                        bytes[k][7:6] = 2'b11;
                end
                // mostly enough bytes, sometimes a short window
                avail = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, len - 1)) :
                        3'($urandom_range(len, 7));
            end
            else if (pick < 85)
            begin
                // stray continuation or out-of-range lead byte
                bytes[0] = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hbf)) :
                           8'($urandom_range(8'hf8, 8'hff));
            end
            send_window({bytes[0], bytes[1], bytes[2], bytes[3], avail}, 1'b0, NO_DECODE);
        end

        win_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: utf8_decode_and_classify_unit.f
rtl/core/utf8dc_pkg.sv
rtl/core/utf8_decode_and_classify_unit.sv
tb/tb_utf8_decode_and_classify_unit.sv
